>>> src/ltc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types, constants and character-class helpers for the lexical token
// classifier.
// ----------------------------------------------------------------------------
package ltc_pkg;

  // default table geometry
  localparam int MAX_KEYWORDS_DEF = 32;
  localparam int MAX_CHARS_DEF    = 9;

  // fixed field widths
  localparam int CH_W  = 8;
  localparam int KI_W  = 5;
  localparam int CP_W  = 4;
  localparam int KC_W  = 6;
  localparam int TL_W  = 4;

  // item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_TOKEN = 1'b1;

  // character codes
  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CH_W-1:0] CH_PCT    = 8'h25;
  localparam logic [CH_W-1:0] CH_LBRK   = 8'h5B;
  localparam logic [CH_W-1:0] CH_RBRK   = 8'h5D;
  localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CH_W-1:0] CH_LPAR   = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAR   = 8'h29;
  localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CH_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CH_W-1:0] CH_0      = 8'h30;
  localparam logic [CH_W-1:0] CH_9      = 8'h39;
  localparam logic [CH_W-1:0] CH_LA     = 8'h61;
  localparam logic [CH_W-1:0] CH_LZ     = 8'h7A;
  localparam logic [CH_W-1:0] CH_UA     = 8'h41;
  localparam logic [CH_W-1:0] CH_UZ     = 8'h5A;

  typedef enum logic [2:0] {
    CLS_KEYWORD  = 3'd0,
    CLS_IDENT    = 3'd1,
    CLS_NUMBER   = 3'd2,
    CLS_BRACKET  = 3'd3,
    CLS_OPERATOR = 3'd4,
    CLS_UNDEF    = 3'd5
  } token_class_t;

  typedef struct packed {
    logic            mode;
    logic [CH_W-1:0] ch;
    logic            last;
    logic [KI_W-1:0] keyword_index;
    logic [CP_W-1:0] char_pos;
  } in_item_t;

  typedef struct packed {
    token_class_t    token_class;
    logic [TL_W-1:0] token_length;
  } out_item_t;

  // token flags handed from the front end to the sequencer
  typedef struct packed {
    logic ident_ok;
    logic number_ok;
    logic too_long;
    logic one_char;
  } tok_status_t;

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_letter(input logic [CH_W-1:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  function automatic logic is_bracket(input logic [CH_W-1:0] c);
    return (c == CH_LBRK) || (c == CH_RBRK) || (c == CH_LBRACE) ||
           (c == CH_RBRACE) || (c == CH_LPAR) || (c == CH_RPAR);
  endfunction

  function automatic logic is_operator(input logic [CH_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_SLASH) || (c == CH_PCT);
  endfunction

  // class of a token of legal length that matched no keyword
  function automatic token_class_t fallback_class(input tok_status_t st,
                                                  input logic [CH_W-1:0] c0);
    token_class_t cls;
    if (st.ident_ok) begin
      cls = CLS_IDENT;
    end else if (st.number_ok) begin
      cls = CLS_NUMBER;
    end else if (st.one_char && is_bracket(c0)) begin
      cls = CLS_BRACKET;
    end else if (st.one_char && is_operator(c0)) begin
      cls = CLS_OPERATOR;
    end else begin
      cls = CLS_UNDEF;
    end
    return cls;
  endfunction

endpackage

>>> src/ltc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ltc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

>>> src/ltc_token_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_token_front
// Collects token characters into a small buffer and tracks the running
// identifier / number flags and the saturating character count.
// ----------------------------------------------------------------------------
module ltc_token_front #(
  parameter int MAX_CHARS = ltc_pkg::MAX_CHARS_DEF,
  localparam int CNT_W    = $clog2(MAX_CHARS + 2),
  localparam int IDX_W    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    tok_en,
  input  logic [ltc_pkg::CH_W-1:0] ch,
  input  logic                    clear,
  input  logic [IDX_W-1:0]        rd_idx,
  output logic [ltc_pkg::CH_W-1:0] rd_char,
  output logic [ltc_pkg::CH_W-1:0] first_char,
  output logic [CNT_W-1:0]        count,
  output ltc_pkg::tok_status_t    status
);

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_CHARS);
  localparam logic [CNT_W-1:0] CNT_LONG = CNT_W'(MAX_CHARS + 1);

  logic [ltc_pkg::CH_W-1:0] buf_r [MAX_CHARS];
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     ident_r, ident_nxt;
  logic                     number_r, number_nxt;
  logic                     dot_r, dot_nxt;
  logic                     c_digit;
  logic                     c_word;

  assign c_digit = ltc_pkg::is_digit(ch);
  assign c_word  = ltc_pkg::is_letter(ch) || c_digit || (ch == ltc_pkg::CH_UNDER);

  // next token flags
  always_comb begin
    count_nxt  = count_r;
    ident_nxt  = ident_r;
    number_nxt = number_r;
    dot_nxt    = dot_r;
    if (clear) begin
      count_nxt  = '0;
      ident_nxt  = 1'b1;
      number_nxt = 1'b1;
      dot_nxt    = 1'b0;
    end else if (tok_en) begin
      if ((count_r == '0) && c_digit) begin
        ident_nxt = 1'b0;
      end
      if (!c_word) begin
        ident_nxt = 1'b0;
      end
      if (!c_digit) begin
        if ((ch == ltc_pkg::CH_DOT) && !dot_r) begin
          dot_nxt = 1'b1;
        end else begin
          number_nxt = 1'b0;
        end
      end
      if (count_r < CNT_LONG) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  // flag and count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ident_r  <= 1'b1;
      number_r <= 1'b1;
      dot_r    <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      ident_r  <= ident_nxt;
      number_r <= number_nxt;
      dot_r    <= dot_nxt;
    end
  end

  // character buffer, characters past the limit are dropped
  always_ff @(posedge clk) begin
    if (tok_en && (count_r < CNT_MAX)) begin
      buf_r[count_r[IDX_W-1:0]] <= ch;
    end
  end

  assign rd_char         = buf_r[rd_idx];
  assign first_char      = buf_r[0];
  assign count           = count_r;
  assign status.ident_ok  = ident_r;
  assign status.number_ok = number_r;
  assign status.too_long  = (count_r > CNT_MAX);
  assign status.one_char  = (count_r == CNT_W'(1));

endmodule

>>> src/ltc_kw_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_kw_seq
// Keyword walk sequencer: reads each keyword's length, then compares one
// character per cycle with a single byte comparator, then issues the result.
// ----------------------------------------------------------------------------
module ltc_kw_seq #(
  parameter int MAX_KEYWORDS = ltc_pkg::MAX_KEYWORDS_DEF,
  parameter int MAX_CHARS    = ltc_pkg::MAX_CHARS_DEF,
  localparam int CNT_W       = $clog2(MAX_CHARS + 2),
  localparam int IDX_W       = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1,
  localparam int LEN_W       = $clog2(MAX_CHARS + 1),
  localparam int KW_IW       = (MAX_KEYWORDS > 1) ? $clog2(MAX_KEYWORDS) : 1,
  localparam int SA_W        = (MAX_KEYWORDS * MAX_CHARS > 1) ?
                               $clog2(MAX_KEYWORDS * MAX_CHARS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  ltc_pkg::tok_status_t     status,
  input  logic [CNT_W-1:0]         count,
  input  logic [ltc_pkg::CH_W-1:0] first_char,
  input  logic [ltc_pkg::KC_W-1:0] kw_count,
  output logic [IDX_W-1:0]         tok_rd_idx,
  input  logic [ltc_pkg::CH_W-1:0] tok_rd_char,
  output logic                     len_re,
  output logic [KW_IW-1:0]         len_raddr,
  input  logic [LEN_W-1:0]         len_rdata,
  output logic                     chr_re,
  output logic [SA_W-1:0]          chr_raddr,
  input  logic [ltc_pkg::CH_W-1:0] chr_rdata,
  output logic                     busy,
  output logic                     clear,
  output logic                     out_valid,
  output ltc_pkg::out_item_t       out_data
);

  localparam int NW = 9;
  localparam int CW = 7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_LEN,
    S_CMP
  } state_t;

  state_t                state_r, state_nxt;
  logic [NW-1:0]         kw_r, kw_nxt;
  logic [SA_W-1:0]       base_r, base_nxt;
  logic [IDX_W-1:0]      j_r, j_nxt;
  logic [IDX_W-1:0]      j_inc;
  logic [NW-1:0]         n_eff;
  logic                  emit;
  ltc_pkg::token_class_t emit_cls;
  logic                  out_valid_r;
  ltc_pkg::out_item_t    out_data_r;
  logic                  len_match;
  logic                  chr_match;
  logic                  last_pos;
  ltc_pkg::token_class_t fb_cls;

  // entries that take part, clipped to the table size
  assign n_eff = (NW'(kw_count) > NW'(MAX_KEYWORDS)) ? NW'(MAX_KEYWORDS) : NW'(kw_count);

  assign j_inc     = j_r + IDX_W'(1);
  assign len_match = (CW'(len_rdata) == CW'(count));
  assign chr_match = (chr_rdata == tok_rd_char);
  assign last_pos  = (CW'(j_r) + CW'(1) == CW'(len_rdata));
  assign fb_cls    = ltc_pkg::fallback_class(status, first_char);

  // table read addresses
  assign tok_rd_idx = j_r;
  assign len_re     = (state_r == S_LEN);
  assign len_raddr  = kw_r[KW_IW-1:0];
  assign chr_raddr  = (state_r == S_LEN) ? base_r : (base_r + SA_W'(j_inc));
  assign chr_re     = (state_r == S_LEN) ||
                      ((state_r == S_CMP) && len_match && chr_match && !last_pos);

  // walk control
  always_comb begin
    state_nxt = state_r;
    kw_nxt    = kw_r;
    base_nxt  = base_r;
    j_nxt     = j_r;
    emit      = 1'b0;
    emit_cls  = ltc_pkg::CLS_UNDEF;
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        kw_nxt   = '0;
        base_nxt = '0;
        if (status.too_long) begin
          emit     = 1'b1;
          emit_cls = ltc_pkg::CLS_UNDEF;
        end else if (n_eff == '0) begin
          emit     = 1'b1;
          emit_cls = fb_cls;
        end else begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        j_nxt     = '0;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (len_match && chr_match && last_pos) begin
          emit     = 1'b1;
          emit_cls = ltc_pkg::CLS_KEYWORD;
        end else if (len_match && chr_match) begin
          j_nxt = j_inc;
        end else if (kw_r + NW'(1) == n_eff) begin
          emit     = 1'b1;
          emit_cls = fb_cls;
        end else begin
          kw_nxt    = kw_r + NW'(1);
          base_nxt  = base_r + SA_W'(MAX_CHARS);
          state_nxt = S_LEN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (emit) begin
      state_nxt = S_IDLE;
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
    end
    kw_r   <= kw_nxt;
    base_r <= base_nxt;
    j_r    <= j_nxt;
    if (emit) begin
      out_data_r.token_class  <= emit_cls;
      out_data_r.token_length <= ltc_pkg::TL_W'(count);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign clear     = emit;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/lexical_token_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexical_token_classifier_unit
// Keyword-table token classifier: loads keywords, streams token characters
// and classifies each finished token.
// ----------------------------------------------------------------------------
//  channel   handshake            payload          notes
//  input     start / busy         in_data          load or token character
//  result    out_valid (strobe)   out_data         one cycle, no back-pressure
//  config    cfg_valid/cfg_ready  cfg_data         keyword count, idle only
//
//  A load item or a token character without the last flag does not raise busy.
//  A last token character holds busy through a check state and then, for
//  each walked keyword, a length read and a compare of its characters,
//  done by the single byte comparator walking the keyword RAM one read per
//  cycle. The result strobe comes in the cycle busy drops.
//  Reset (rst_n low, synchronous) clears the token state and keyword count;
//  keyword table contents are not cleared. Results are never stalled.
// ----------------------------------------------------------------------------
module lexical_token_classifier_unit #(
  parameter int MAX_KEYWORDS = ltc_pkg::MAX_KEYWORDS_DEF,
  parameter int MAX_CHARS    = ltc_pkg::MAX_CHARS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  ltc_pkg::in_item_t        in_data,
  output logic                     out_valid,
  output ltc_pkg::out_item_t       out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [ltc_pkg::KC_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_CHARS + 2);
  localparam int IDX_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int LEN_W = $clog2(MAX_CHARS + 1);
  localparam int KW_IW = (MAX_KEYWORDS > 1) ? $clog2(MAX_KEYWORDS) : 1;
  localparam int SA_W  = (MAX_KEYWORDS * MAX_CHARS > 1) ?
                         $clog2(MAX_KEYWORDS * MAX_CHARS) : 1;
  localparam int AW    = 16;
  localparam int PW    = 9;

  logic                     accept;
  logic                     tok_en;
  logic                     go;
  logic                     ld_ok;
  logic [ltc_pkg::KC_W-1:0] kc_r;
  logic                     clear;
  logic [IDX_W-1:0]         tok_rd_idx;
  logic [ltc_pkg::CH_W-1:0] tok_rd_char;
  logic [ltc_pkg::CH_W-1:0] first_char;
  logic [CNT_W-1:0]         count;
  ltc_pkg::tok_status_t     status;
  logic                     len_re;
  logic [KW_IW-1:0]         len_raddr;
  logic [LEN_W-1:0]         len_rdata;
  logic                     chr_re;
  logic [SA_W-1:0]          chr_raddr;
  logic [ltc_pkg::CH_W-1:0] chr_rdata;
  logic [AW-1:0]            ld_addr;

  // input transaction decode
  assign accept = start && !busy;
  assign tok_en = accept && (in_data.mode == ltc_pkg::MODE_TOKEN);
  assign go     = tok_en && in_data.last;
  assign ld_ok  = accept && (in_data.mode == ltc_pkg::MODE_LOAD) &&
                  (PW'(in_data.keyword_index) < PW'(MAX_KEYWORDS)) &&
                  (PW'(in_data.char_pos) < PW'(MAX_CHARS));
  assign ld_addr = AW'(in_data.keyword_index) * AW'(MAX_CHARS) + AW'(in_data.char_pos);

  // keyword count register
  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kc_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      kc_r <= cfg_data;
    end
  end

  // keyword characters
  ltc_ram #(
    .WIDTH (ltc_pkg::CH_W),
    .DEPTH (MAX_KEYWORDS * MAX_CHARS)
  ) u_chr_ram (
    .clk     (clk),
    .we      (ld_ok),
    .waddr   (ld_addr[SA_W-1:0]),
    .wdata   (in_data.ch),
    .re      (chr_re),
    .raddr   (chr_raddr),
    .rdata_r (chr_rdata)
  );

  // keyword lengths
  ltc_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MAX_KEYWORDS)
  ) u_len_ram (
    .clk     (clk),
    .we      (ld_ok && in_data.last),
    .waddr   (KW_IW'(in_data.keyword_index)),
    .wdata   (LEN_W'(PW'(in_data.char_pos) + PW'(1))),
    .re      (len_re),
    .raddr   (len_raddr),
    .rdata_r (len_rdata)
  );

  // token collection
  ltc_token_front #(
    .MAX_CHARS (MAX_CHARS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_en     (tok_en),
    .ch         (in_data.ch),
    .clear      (clear),
    .rd_idx     (tok_rd_idx),
    .rd_char    (tok_rd_char),
    .first_char (first_char),
    .count      (count),
    .status     (status)
  );

  // keyword walk and result
  ltc_kw_seq #(
    .MAX_KEYWORDS (MAX_KEYWORDS),
    .MAX_CHARS    (MAX_CHARS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .status      (status),
    .count       (count),
    .first_char  (first_char),
    .kw_count    (kc_r),
    .tok_rd_idx  (tok_rd_idx),
    .tok_rd_char (tok_rd_char),
    .len_re      (len_re),
    .len_raddr   (len_raddr),
    .len_rdata   (len_rdata),
    .chr_re      (chr_re),
    .chr_raddr   (chr_raddr),
    .chr_rdata   (chr_rdata),
    .busy        (busy),
    .clear       (clear),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule
